// ===== sv/unique_color_palette_builder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the unique color palette builder
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_COLOR_PALETTE_BUILDER_MACROS_SVH
`define UNIQUE_COLOR_PALETTE_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge.
`define UCPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle that implies a consequence in the next cycle.
`define UCPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UCPB_ASSERT(label, prop, msg)
`define UCPB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/ucpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Unique color palette builder package
// Shared sizes, item types and result codes.
// ----------------------------------------------------------------------------
package ucpb_pkg;

  // Table size and the widths that follow from it.
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the interface.
  localparam int COLOR_W  = 24;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int LIMIT_W  = 9;
  localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Output data bus: index then count, padded to whole bytes.
  localparam int ODATA_USED = INDEX_W + COUNT_W;
  localparam int ODATA_W    = ((ODATA_USED + 7) / 8) * 8;
  localparam int ODATA_PAD  = ODATA_W - ODATA_USED;

  // Input queue between the front and the back part.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CMP_W-1:0]   cmp_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  localparam limit_t LIMIT_RESET = limit_t'(256);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_ADDED   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // Pixel command handed from the front to the back part.
  typedef struct packed {
    color_t color;
    logic   first;
    logic   last;
  } cmd_t;

  // Result item.
  typedef struct packed {
    status_e status;
    index_t  index;
    count_t  count;
    logic    done;
  } res_t;

endpackage

// ===== sv/ucpb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ucpb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ucpb_front.sv =====
// ----------------------------------------------------------------------------
// Palette builder front part
// Accepts pixel items, sorts their fields into a command and holds them in
// a short queue so that the input side can run ahead of the table search.
// ----------------------------------------------------------------------------
module ucpb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ucpb_pkg::color_t      in_color_i,
  input  logic                  in_first_i,
  input  logic                  in_last_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output ucpb_pkg::cmd_t        cmd_o
);

  ucpb_pkg::cmd_t                       slot_q [ucpb_pkg::QDEPTH];
  logic [ucpb_pkg::QPTR_W-1:0]          wr_ptr_q, rd_ptr_q;
  logic [ucpb_pkg::QCNT_W-1:0]          fill_q;
  logic                                 push, pop;
  ucpb_pkg::cmd_t                       cmd_in;

  // Classify the incoming pixel into a command.
  always_comb begin
    cmd_in.color = in_color_i;
    cmd_in.first = in_first_i;
    cmd_in.last  = in_last_i;
  end

  assign in_ready_o  = (fill_q != ucpb_pkg::QCNT_W'(ucpb_pkg::QDEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == ucpb_pkg::QPTR_W'(ucpb_pkg::QDEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == ucpb_pkg::QPTR_W'(ucpb_pkg::QDEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/ucpb_back.sv =====
// ----------------------------------------------------------------------------
// Palette builder back part
// Searches the color table one entry per cycle, appends new colors or
// latches the stopped state, and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "unique_color_palette_builder_macros.svh"

module ucpb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ucpb_pkg::limit_t      limit_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  ucpb_pkg::cmd_t        cmd_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ucpb_pkg::res_t        res_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e                state_q, state_d;
  ucpb_pkg::cnt_t        count_q, count_d;
  logic                  stopped_q, stopped_d;
  ucpb_pkg::addr_t       idx_q, idx_d;
  ucpb_pkg::color_t      color_q, color_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  ucpb_pkg::res_t        out_q, out_d;

  logic                  slot_free, launch;
  ucpb_pkg::cnt_t        cnt_eff;
  logic                  stop_eff;
  logic                  ins_go;
  ucpb_pkg::cnt_t        ins_cnt;
  logic                  limit_hit;
  logic                  at_end;

  logic                  we;
  ucpb_pkg::addr_t       waddr, raddr;
  ucpb_pkg::color_t      rdata;

  ucpb_ram #(
    .WIDTH (ucpb_pkg::COLOR_W),
    .DEPTH (ucpb_pkg::CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (color_d),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Handshake with the queue: one item at a time, and only when the
  // output register is empty or being emptied.
  assign slot_free   = !out_valid_q || res_ready_i;
  assign launch      = (state_q == S_IDLE) && cmd_valid_i && slot_free;
  assign cmd_ready_o = launch;

  // A first pixel starts from an empty, running table.
  assign cnt_eff  = cmd_i.first ? '0 : count_q;
  assign stop_eff = cmd_i.first ? 1'b0 : stopped_q;

  // Entry 0 is read while idle; each search cycle fetches the next entry.
  assign raddr  = (state_q == S_IDLE) ? '0 : idx_q + 1'b1;
  assign at_end = (ucpb_pkg::cnt_t'(idx_q) + ucpb_pkg::cnt_t'(1) == count_q);

  // Limit check for an insert; the limit saturates at the table size.
  assign limit_hit = (ucpb_pkg::cmp_t'(ins_cnt) >= ucpb_pkg::cmp_t'(limit_i)) ||
                     (ins_cnt == ucpb_pkg::cnt_t'(ucpb_pkg::CAPACITY));

  // Next-state and result logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    idx_d       = idx_q;
    color_d     = color_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    ins_go      = 1'b0;
    ins_cnt     = count_q;
    we          = 1'b0;
    waddr       = ins_cnt[ucpb_pkg::ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (launch) begin
          color_d   = cmd_i.color;
          last_d    = cmd_i.last;
          count_d   = cnt_eff;
          stopped_d = stop_eff;
          idx_d     = '0;
          if (stop_eff) begin
            out_valid_d  = 1'b1;
            out_d.status = ucpb_pkg::ST_IGNORED;
            out_d.index  = '0;
            out_d.count  = ucpb_pkg::count_t'(cnt_eff);
            out_d.done   = cmd_i.last;
          end else if (cnt_eff == '0) begin
            ins_go  = 1'b1;
            ins_cnt = cnt_eff;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (rdata == color_q) begin
          state_d      = S_IDLE;
          out_valid_d  = 1'b1;
          out_d.status = ucpb_pkg::ST_MATCH;
          out_d.index  = ucpb_pkg::index_t'(idx_q);
          out_d.count  = ucpb_pkg::count_t'(count_q);
          out_d.done   = last_q;
        end else if (at_end) begin
          state_d = S_IDLE;
          ins_go  = 1'b1;
          ins_cnt = count_q;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Append the new color, or stop when the table has reached its limit.
    waddr = ins_cnt[ucpb_pkg::ADDR_W-1:0];
    if (ins_go) begin
      out_valid_d = 1'b1;
      out_d.done  = last_d;
      if (limit_hit) begin
        stopped_d    = 1'b1;
        out_d.status = ucpb_pkg::ST_IGNORED;
        out_d.index  = '0;
        out_d.count  = ucpb_pkg::count_t'(ins_cnt);
      end else begin
        we           = 1'b1;
        count_d      = ins_cnt + 1'b1;
        out_d.status = ucpb_pkg::ST_ADDED;
        out_d.index  = ucpb_pkg::index_t'(ins_cnt[ucpb_pkg::ADDR_W-1:0]);
        out_d.count  = ucpb_pkg::count_t'(ins_cnt + 1'b1);
      end
    end
  end

  // State, table count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload, no reset needed.
  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    last_q  <= last_d;
    out_q   <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // The table never holds more colors than it has entries.
  `UCPB_ASSERT(a_count_bound, count_q <= ucpb_pkg::cnt_t'(ucpb_pkg::CAPACITY), "count overflow")
  // The search only visits stored entries.
  `UCPB_ASSERT(a_search_in_range, (state_q == S_SEARCH) |-> (ucpb_pkg::cnt_t'(idx_q) < count_q), "search beyond stored entries")
  // An ignored pixel reports index zero.
  `UCPB_ASSERT(a_ignored_index, (out_valid_q && out_q.status == ucpb_pkg::ST_IGNORED) |-> (out_q.index == '0), "ignored result with nonzero index")
  // Appending a color updates the stored count.
  `UCPB_ASSERT_NEXT(a_add_counts, we, count_q == $past(count_d), "count not updated on append")

endmodule

// ===== sv/unique_color_palette_builder.sv =====
// ----------------------------------------------------------------------------
// Unique color palette builder
// Builds a table of the distinct colors of an image in order of appearance.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel: tdata carries red, green and blue,
//   tuser marks the first pixel of an image (clears the table and the stopped
//   state) and tlast marks the final pixel. Each pixel yields exactly one item
//   on the m_axis channel: tuser holds the status (matched, added, ignored),
//   tdata the entry index and the count of stored colors, tlast echoes the
//   final-pixel mark.
//   The entry limit must be written on the cfg channel while the block is
//   idle (the user's duty); it resets to 256 and saturates at table size.
// Search:
//   A pixel on a running table is compared with the stored colors one entry
//   at a time, up to a match or the last one, before its result appears
//   in the output register. The table sits in one single-port-read RAM,
//   and the entry-by-entry search over that read port sets the rate.
//   A two-item queue keeps accepting pixels while the search runs.
// Reset: the table is empty, the block runs, and no result is pending.
// Stall: a held result stops the search of the next pixel; the input
//   queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module unique_color_palette_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Pixel input. tdata: red [7:0], green [15:8], blue [23:16].
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ucpb_pkg::COLOR_W-1:0] s_axis_tdata,
  // tuser: first_pixel.
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tlast,
  // Result output. tdata: entry_index [7:0], entry_count [16:8], zero fill.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ucpb_pkg::ODATA_W-1:0] m_axis_tdata,
  // tuser: status.
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast,
  // Entry limit register write.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  ucpb_pkg::limit_t             cfg_data_i
);

  ucpb_pkg::limit_t  limit_q;
  logic              cmd_valid, cmd_ready;
  ucpb_pkg::cmd_t    cmd;
  logic              res_valid;
  ucpb_pkg::res_t    res;

  // Entry limit register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ucpb_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  ucpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_color_i  (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ucpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result onto the output channel.
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{ucpb_pkg::ODATA_PAD{1'b0}}, res.count, res.index};
  assign m_axis_tuser  = res.status;
  assign m_axis_tlast  = res.done;

endmodule

// ===== test/unique_color_palette_builder_tb.sv =====
// ----------------------------------------------------------------------------
// Unique color palette builder testbench
// Streams pixel items through the block and checks every result item against
// a local model of the color table, the stored count and the stopped state.
// A short directed part covers the table edges and the limit corner cases.
// Random images follow under several limit values and idling patterns.
// ----------------------------------------------------------------------------
module unique_color_palette_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run length guard and the long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_PIXELS   = 75;

  // One pixel waiting to be driven.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first;
    logic       last;
  } pixel_t;

  // Clock, reset and DUT ports.
  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [ucpb_pkg::COLOR_W-1:0] s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [ucpb_pkg::ODATA_W-1:0] m_axis_tdata;
  logic [1:0]                   m_axis_tuser;
  logic                         m_axis_tlast;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  ucpb_pkg::limit_t             cfg_data_i    = ucpb_pkg::LIMIT_RESET;

  // Pixels still to be driven and results still to arrive.
  pixel_t         pixel_queue[$];
  ucpb_pkg::res_t expected_results[$];
  int unsigned    pushed_cnt   = 0;
  int unsigned    accepted_cnt = 0;
  int unsigned    mismatch_cnt = 0;

  // Idling controls shared with the driver and the receiver.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  bit          hold_started   = 1'b0;
  int unsigned hold_left      = 0;
  bit          pixel_taken    = 1'b0;

  // Local copy of the color table state.
  ucpb_pkg::color_t palette[ucpb_pkg::CAPACITY];
  int unsigned      palette_size = 0;
  bit               palette_full = 1'b0;
  int unsigned      entry_limit_q = 256;

  // Scratch variables of the clocked processes.
  pixel_t         drive_px;
  ucpb_pkg::res_t want_res;
  ucpb_pkg::res_t seen_res;

  unique_color_palette_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Expected result of one pixel; updates the local table state.
  function automatic ucpb_pkg::res_t predict_pixel(input ucpb_pkg::color_t color,
                                                   input logic first, input logic last);
    ucpb_pkg::res_t r;
    int             found_at;
    int unsigned    lim;
    r.status = ucpb_pkg::ST_IGNORED;
    r.index  = '0;
    if (first) begin
      palette_size = 0;
      palette_full = 1'b0;
    end
    if (!palette_full) begin
      found_at = -1;
      for (int i = 0; i < palette_size; i++) begin
        if (found_at < 0 && palette[i] == color) found_at = i;
      end
      lim = (entry_limit_q > ucpb_pkg::CAPACITY) ? ucpb_pkg::CAPACITY : entry_limit_q;
      if (found_at >= 0) begin
        r.status = ucpb_pkg::ST_MATCH;
        r.index  = ucpb_pkg::index_t'(found_at);
      end else if (palette_size >= lim) begin
        // A new color on a full table stops the image and is itself ignored.
        palette_full = 1'b1;
      end else begin
        palette[palette_size] = color;
        r.status = ucpb_pkg::ST_ADDED;
        r.index  = ucpb_pkg::index_t'(palette_size);
        palette_size++;
      end
    end
    r.count = ucpb_pkg::count_t'(palette_size);
    r.done  = last;
    return r;
  endfunction

  // Pixel driver: a new item goes out only once the previous one was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pixel_taken) begin
      pixel_taken = 1'b0;
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_px = pixel_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_px.blue, drive_px.green, drive_px.red};
        s_axis_tuser  <= drive_px.first;
        s_axis_tlast  <= drive_px.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted pixel and checks each result item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) entry_limit_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        pixel_taken = 1'b1;
        accepted_cnt++;
        expected_results.push_back(predict_pixel(
          {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]},
          s_axis_tuser, s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res.status = ucpb_pkg::status_e'(m_axis_tuser);
        seen_res.index  = m_axis_tdata[ucpb_pkg::INDEX_W-1:0];
        seen_res.count  = m_axis_tdata[ucpb_pkg::ODATA_USED-1:ucpb_pkg::INDEX_W];
        seen_res.done   = m_axis_tlast;
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Unexpected result item: status %0d index %0d count %0d done %0b",
                     m_axis_tuser, seen_res.index, seen_res.count, seen_res.done);
        end else begin
          want_res = expected_results.pop_front();
          if (m_axis_tuser !== want_res.status || seen_res.index !== want_res.index ||
              seen_res.count !== want_res.count || seen_res.done !== want_res.done ||
              m_axis_tdata[ucpb_pkg::ODATA_W-1:ucpb_pkg::ODATA_USED] !== '0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("Result mismatch: expected status %0d index %0d count %0d done %0b",
                       want_res.status, want_res.index, want_res.count, want_res.done);
              $display("  got status %0d index %0d count %0d done %0b fill %h",
                       m_axis_tuser, seen_res.index, seen_res.count, seen_res.done,
                       m_axis_tdata[ucpb_pkg::ODATA_W-1:ucpb_pkg::ODATA_USED]);
            end
          end
        end
      end
    end
  end

  // Timeout guard.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Adds one pixel to the driver queue.
  task automatic push_pixel(input ucpb_pkg::color_t color, input logic first,
                            input logic last);
    pixel_t p;
    p.red   = color[23:16];
    p.green = color[15:8];
    p.blue  = color[7:0];
    p.first = first;
    p.last  = last;
    pixel_queue.push_back(p);
    pushed_cnt++;
  endtask

  // Waits until every queued pixel has been taken and answered.
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes the entry limit register; only called while the block is idle.
  task automatic write_limit(input int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ucpb_pkg::limit_t'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Queues one image drawn from a small random palette, mixed with stray
  // colors from outside it. A noisy image may lack its first mark or carry
  // stray first or last marks.
  task automatic queue_image(input int unsigned len, input int unsigned ncolors,
                             input bit noisy);
    ucpb_pkg::color_t colors[$];
    ucpb_pkg::color_t c;
    logic             first;
    logic             last;
    for (int k = 0; k < ncolors; k++) colors.push_back(ucpb_pkg::color_t'($urandom));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(7) == 0) c = ucpb_pkg::color_t'($urandom);
      else c = colors[$urandom_range(ncolors - 1)];
      if (noisy) begin
        first = (k == 0 && $urandom_range(3) != 0) || $urandom_range(19) == 0;
        last  = (k == len - 1) || $urandom_range(9) == 0;
      end else begin
        first = (k == 0);
        last  = (k == len - 1);
      end
      push_pixel(c, first, last);
    end
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned phase_limits[RANDOM_PHASES];
    int unsigned send_pcts[4];
    int unsigned recv_pcts[4];
    int unsigned phase_pixels;
    int unsigned len;
    int unsigned ncolors;

    phase_limits = '{256, 1, 0, 511, 3, 257, 12, 255, 2, 40, 300, 7};
    send_pcts    = '{0, 61, 0, 37};
    recv_pcts    = '{0, 0, 61, 37};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pixels before any first mark, against the empty table at reset limit.
    push_pixel(24'h000000, 1'b0, 1'b0);
    push_pixel(24'hFFFFFF, 1'b0, 1'b0);
    push_pixel(24'h000000, 1'b0, 1'b0);
    push_pixel(24'hFFFFFF, 1'b0, 1'b1);
    wait_idle();

    // Limit of one: the second new color stops the image, matches are then ignored.
    write_limit(1);
    push_pixel(24'h123456, 1'b1, 1'b0);
    push_pixel(24'h123456, 1'b0, 1'b0);
    push_pixel(24'hAABBCC, 1'b0, 1'b0);
    push_pixel(24'h123456, 1'b0, 1'b1);
    push_pixel(24'h00FF00, 1'b1, 1'b1);
    wait_idle();

    // Limit of zero: the first new color stops the image.
    write_limit(0);
    push_pixel(24'hFF0000, 1'b1, 1'b0);
    push_pixel(24'hFF0000, 1'b0, 1'b1);
    wait_idle();

    // Limit above the table size, then lowered in the middle of an image.
    write_limit(511);
    push_pixel(24'h0000FF, 1'b1, 1'b0);
    push_pixel(24'h00FF00, 1'b0, 1'b0);
    push_pixel(24'hFF0000, 1'b0, 1'b0);
    push_pixel(24'h0000FF, 1'b0, 1'b0);
    wait_idle();
    write_limit(2);
    push_pixel(24'hFF0000, 1'b0, 1'b0);
    push_pixel(24'h00FF00, 1'b0, 1'b0);
    push_pixel(24'h5A5A5A, 1'b0, 1'b0);
    push_pixel(24'h0000FF, 1'b0, 1'b1);
    wait_idle();

    // Full table under a saturated limit: 256 distinct colors, a match on the
    // last entry, then the stopping pixel and one ignored pixel.
    write_limit(511);
    send_idle_pct  = send_pcts[3];
    recv_stall_pct = recv_pcts[3];
    for (int k = 0; k < ucpb_pkg::CAPACITY; k++)
      push_pixel({8'(k), 8'(~k), 8'(k * 7)}, k == 0, 1'b0);
    push_pixel({8'(ucpb_pkg::CAPACITY - 1), 8'(~(ucpb_pkg::CAPACITY - 1)),
                8'((ucpb_pkg::CAPACITY - 1) * 7)}, 1'b0, 1'b0);
    push_pixel(24'h000001, 1'b0, 1'b0);
    push_pixel(24'h000000, 1'b0, 1'b1);
    wait_idle();

    // Random images under a range of limits and idling patterns.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle_pct  = send_pcts[ph % 4];
      recv_stall_pct = recv_pcts[ph % 4];
      write_limit(phase_limits[ph]);
      // A long receiver hold-off while the sender keeps pushing items.
      if (ph == 0) hold_request = 1'b1;
      phase_pixels = 0;
      while (phase_pixels < PHASE_PIXELS) begin
        if ($urandom_range(9) == 0) begin
          len     = $urandom_range(20, 80);
          ncolors = $urandom_range(10, 60);
        end else begin
          len     = $urandom_range(3, 40);
          ncolors = $urandom_range(1, 20);
        end
        queue_image(len, ncolors, $urandom_range(5) == 0);
        phase_pixels += len;
      end
      wait_idle();
    end

    // Let any stray result item show up before the verdict.
    repeat (ucpb_pkg::CAPACITY + 20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatch_cnt++;
      $display("%0d result items never arrived", expected_results.size());
    end
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ucpb_pkg.sv
sv/ucpb_ram.sv
sv/ucpb_front.sv
sv/ucpb_back.sv
sv/unique_color_palette_builder.sv
test/unique_color_palette_builder_tb.sv
